// ===== design/bed_pkg.sv =====
// Shared types, character codes and decode helpers for the backslash escape decoder.
package bed_pkg;

  // Result words that one input byte can give at most.
  localparam int MAX_RES = 4;
  localparam int CNT_W   = 3;
  localparam int IDX_W   = 2;

  // Decoder phases.
  localparam logic [3:0] PH_PLAIN    = 4'd0;
  localparam logic [3:0] PH_ESC      = 4'd1;
  localparam logic [3:0] PH_DIG1     = 4'd2;
  localparam logic [3:0] PH_DIG2     = 4'd3;
  localparam logic [3:0] PH_HEXSTART = 4'd4;
  localparam logic [3:0] PH_HEX2     = 4'd5;
  localparam logic [3:0] PH_GROUP    = 4'd6;
  localparam logic [3:0] PH_GHEX2    = 4'd7;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LONE_BSL  = 3'd1;
  localparam logic [2:0] ST_SHORT_HEX = 3'd2;
  localparam logic [2:0] ST_BAD_HEX   = 3'd3;
  localparam logic [2:0] ST_OPEN_BR   = 3'd4;
  localparam logic [2:0] ST_BAD_OCT   = 3'd5;
  localparam logic [2:0] ST_OCT_LARGE = 3'd6;

  // Character codes.
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // One result word.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       end_of_string;
    logic [2:0] status;
  } word_t;

  // All result words of one input byte.
  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    word_t [MAX_RES-1:0]     w;
  } packet_t;

  function automatic logic is_dec(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Letters a-f and A-F have 1..6 in their low nibble, so adding nine gives 10..15.
  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [3:0] v;
    if (is_dec(c)) begin
      v = c[3:0];
    end else if (is_hex(c)) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

  // Appends a data word to a packet while room is left.
  function automatic packet_t add_word(packet_t p, logic [7:0] b);
    packet_t r;
    r = p;
    if (p.cnt < CNT_W'(MAX_RES)) begin
      r.w[p.cnt[IDX_W-1:0]] = '{has_byte: 1'b1, out_byte: b, end_of_string: 1'b0,
                                status: ST_OK};
      r.cnt = p.cnt + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== design/backslash_escape_decoder.sv =====
// Top level of the backslash escape decoder: front end, packet queue and back end.
//
//  channel  direction  handshake              word
//  src      in         src_valid / src_stall  in_byte, is_last
//  res      out        res_valid / res_stall  has_byte, out_byte, end_of_string, status
//  cfg      in         cfg_valid / cfg_ready  cfg_data (strip_all)
//
// The front end decodes one byte per cycle while src_stall is low and pushes the one to
// four result words it gives as a single packet into a QUEUE_DEPTH-entry queue; bytes
// that give no word push nothing. The back end sends one word per cycle while res_stall
// is low and pops a packet with its last word. src_stall is high while the queue is full.
// Reset is synchronous and clears the decoder state, the queue and strip_all.
module backslash_escape_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_stall,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       has_byte,
  output logic [7:0] out_byte,
  output logic       end_of_string,
  output logic [2:0] status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import bed_pkg::*;

  logic    accept;
  logic    push, pop, full, not_empty;
  packet_t pkt, head;
  word_t   word;

  assign cfg_ready = 1'b1;
  assign src_stall = full;
  assign accept    = src_valid && !full;

  // Decoder front end.
  bed_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .is_last (is_last),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_bit (cfg_data),
    .push    (push),
    .pkt     (pkt)
  );

  // Packet queue.
  bed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (pkt),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // Output back end.
  bed_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .res_stall (res_stall),
    .pop       (pop),
    .res_valid (res_valid),
    .word      (word)
  );

  assign has_byte      = word.has_byte;
  assign out_byte      = word.out_byte;
  assign end_of_string = word.end_of_string;
  assign status        = word.status;

endmodule

// ===== design/bed_front.sv =====
// Front end: accepts raw bytes, runs the escape state machine and builds result packets.
module bed_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             is_last,
  input  logic             cfg_we,
  input  logic             cfg_bit,
  output logic             push,
  output bed_pkg::packet_t pkt
);
  import bed_pkg::*;

  logic       strip_all;
  logic [3:0] phase, phase_next;
  logic [7:0] held_first, held_first_next;
  logic [7:0] held_second, held_second_next;
  logic [2:0] error_latch, error_next;
  packet_t    p;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strip_all <= 1'b0;
    end else if (cfg_we) begin
      strip_all <= cfg_bit;
    end
  end

  // Decode of one byte against the current phase.
  always_comb begin
    p                = '0;
    phase_next       = phase;
    held_first_next  = held_first;
    held_second_next = held_second;
    error_next       = error_latch;
    if (error_latch == ST_OK) begin
      case (phase)
        PH_ESC: begin
          phase_next = PH_PLAIN;
          if (in_byte == CH_BSL) begin
            if (!strip_all) p = add_word(p, CH_BSL);
            p = add_word(p, CH_BSL);
          end else if (in_byte == CH_N) begin
            p = add_word(p, CH_LF);
          end else if (in_byte == CH_T) begin
            p = add_word(p, CH_TAB);
          end else if (in_byte == CH_R) begin
            p = add_word(p, CH_CR);
          end else if (in_byte == CH_X) begin
            if (is_last) begin
              error_next = ST_SHORT_HEX;
            end else begin
              phase_next = PH_HEXSTART;
            end
          end else if (is_dec(in_byte) && !is_last) begin
            held_first_next = in_byte;
            phase_next      = PH_DIG1;
          end else begin
            if (!strip_all) p = add_word(p, CH_BSL);
            p = add_word(p, in_byte);
          end
        end
        PH_DIG1: begin
          if (is_dec(in_byte) && !is_last) begin
            held_second_next = in_byte;
            phase_next       = PH_DIG2;
          end else begin
            if (!strip_all) p = add_word(p, CH_BSL);
            p = add_word(p, held_first);
            // The current byte is then taken again as plain text.
            if (in_byte == CH_BSL) begin
              if (is_last) begin
                error_next = ST_LONE_BSL;
                phase_next = PH_PLAIN;
              end else begin
                phase_next = PH_ESC;
              end
            end else begin
              p          = add_word(p, in_byte);
              phase_next = PH_PLAIN;
            end
          end
        end
        PH_DIG2: begin
          if (is_dec(in_byte)) begin
            phase_next = PH_PLAIN;
            if (!is_oct(held_first) || !is_oct(held_second) || !is_oct(in_byte)) begin
              error_next = ST_BAD_OCT;
            end else if (held_first[2]) begin
              error_next = ST_OCT_LARGE;
            end else begin
              p = add_word(p, {held_first[1:0], held_second[2:0], in_byte[2:0]});
            end
          end else begin
            if (!strip_all) p = add_word(p, CH_BSL);
            p = add_word(p, held_first);
            p = add_word(p, held_second);
            if (in_byte == CH_BSL) begin
              if (is_last) begin
                error_next = ST_LONE_BSL;
                phase_next = PH_PLAIN;
              end else begin
                phase_next = PH_ESC;
              end
            end else begin
              p          = add_word(p, in_byte);
              phase_next = PH_PLAIN;
            end
          end
        end
        PH_HEXSTART: begin
          if (in_byte == CH_LBRACE) begin
            if (is_last) begin
              error_next = ST_OPEN_BR;
              phase_next = PH_PLAIN;
            end else begin
              phase_next = PH_GROUP;
            end
          end else if (is_last) begin
            error_next = ST_SHORT_HEX;
            phase_next = PH_PLAIN;
          end else begin
            held_first_next = in_byte;
            phase_next      = PH_HEX2;
          end
        end
        PH_HEX2: begin
          phase_next = PH_PLAIN;
          if (!is_hex(held_first) || !is_hex(in_byte)) begin
            error_next = ST_BAD_HEX;
          end else begin
            p = add_word(p, {hex_val(held_first), hex_val(in_byte)});
          end
        end
        PH_GROUP: begin
          if (in_byte == CH_RBRACE) begin
            phase_next = PH_PLAIN;
          end else if (is_last) begin
            error_next = ST_SHORT_HEX;
            phase_next = PH_PLAIN;
          end else begin
            held_first_next = in_byte;
            phase_next      = PH_GHEX2;
          end
        end
        PH_GHEX2: begin
          if (!is_hex(held_first) || !is_hex(in_byte)) begin
            error_next = ST_BAD_HEX;
            phase_next = PH_PLAIN;
          end else begin
            p          = add_word(p, {hex_val(held_first), hex_val(in_byte)});
            phase_next = PH_GROUP;
            // A pair on the last byte leaves the brace open.
            if (is_last) begin
              error_next = ST_OPEN_BR;
              phase_next = PH_PLAIN;
            end
          end
        end
        default: begin
          if (in_byte == CH_BSL) begin
            if (is_last) begin
              error_next = ST_LONE_BSL;
              phase_next = PH_PLAIN;
            end else begin
              phase_next = PH_ESC;
            end
          end else begin
            p          = add_word(p, in_byte);
            phase_next = PH_PLAIN;
          end
        end
      endcase
    end
    // End of string: mark the last word or append a status word, then clear state.
    if (is_last) begin
      if ((error_next != ST_OK) || (p.cnt == '0)) begin
        if (p.cnt < CNT_W'(MAX_RES)) begin
          p.w[p.cnt[IDX_W-1:0]] = '{has_byte: 1'b0, out_byte: 8'h00, end_of_string: 1'b1,
                                    status: error_next};
          p.cnt = p.cnt + CNT_W'(1);
        end
      end else begin
        p.w[IDX_W'(p.cnt - CNT_W'(1))].end_of_string = 1'b1;
      end
      phase_next       = PH_PLAIN;
      held_first_next  = 8'h00;
      held_second_next = 8'h00;
      error_next       = ST_OK;
    end
  end

  // Decoder state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PLAIN;
      held_first  <= 8'h00;
      held_second <= 8'h00;
      error_latch <= ST_OK;
    end else if (accept) begin
      phase       <= phase_next;
      held_first  <= held_first_next;
      held_second <= held_second_next;
      error_latch <= error_next;
    end
  end

  // Only packets that hold at least one word enter the queue.
  assign push = accept && (p.cnt != '0);
  assign pkt  = p;

endmodule

// ===== design/bed_queue.sv =====
// Short packet queue between the decoder front end and the output back end.
module bed_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bed_pkg::packet_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output bed_pkg::packet_t head
);
  import bed_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  packet_t           slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_QW-1:0] fill;
  logic              do_push, do_pop;

  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign full      = (fill == CNT_QW'(DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  // Packet storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_QW'(1);
      end
    end
  end

endmodule

// ===== design/bed_back.sv =====
// Back end: sends the words of the head packet out one word per cycle while res_stall is low.
module bed_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             not_empty,
  input  bed_pkg::packet_t head,
  input  logic             res_stall,
  output logic             pop,
  output logic             res_valid,
  output bed_pkg::word_t   word
);
  import bed_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             take;
  logic             last_word;

  assign res_valid = not_empty;
  assign word      = head.w[idx];
  assign take      = res_valid && !res_stall;
  assign last_word = ({1'b0, idx} == (head.cnt - CNT_W'(1)));
  assign pop       = take && last_word;

  // Word index within the head packet.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last_word ? '0 : idx + IDX_W'(1);
    end
  end

endmodule
